// File: design/ack_retransmit_tracker_defines.svh
// ----------------------------------------------------------------------------
// ack_retransmit_tracker_defines.svh
// Assertion macros shared by the tracker checks.
// ----------------------------------------------------------------------------
`ifndef ACK_RETRANSMIT_TRACKER_DEFINES_SVH
`define ACK_RETRANSMIT_TRACKER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define ART_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ART_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/art_pkg.sv
// ----------------------------------------------------------------------------
// art_pkg
// Shared types and constants of the ack retransmit tracker.
// ----------------------------------------------------------------------------
package art_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;

  localparam logic [1:0] OP_SEND = 2'd0;
  localparam logic [1:0] OP_ACK  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [2:0] K_IGNORED     = 3'd0;
  localparam logic [2:0] K_NEW         = 3'd1;
  localparam logic [2:0] K_REARM       = 3'd2;
  localparam logic [2:0] K_GIVEUP      = 3'd3;
  localparam logic [2:0] K_FULL        = 3'd4;
  localparam logic [2:0] K_ACKED       = 3'd5;
  localparam logic [2:0] K_ACK_UNKNOWN = 3'd6;
  localparam logic [2:0] K_RESEND      = 3'd7;

  localparam logic CFG_MAX_ATTEMPTS = 1'b0;
  localparam logic CFG_RETRY_TICKS  = 1'b1;

  localparam logic [7:0]  MAX_ATTEMPTS_RST = 8'd3;
  localparam logic [15:0] RETRY_TICKS_RST  = 16'd2000;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] pkg_id;
    logic        no_ack;
  } art_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] result_id;
    logic        last;
  } art_out_t;

  typedef struct packed {
    logic [31:0] id;
    logic [7:0]  attempts;
    logic [15:0] countdown;
  } art_entry_t;

endpackage

// File: design/ack_retransmit_tracker.sv
// ----------------------------------------------------------------------------
// ack_retransmit_tracker
// Table of packet ids waiting for an ack, with retry timers and retry limit.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_data) carries send requests, acks and
// time ticks; the result channel (out_valid/out_stall/out_data) returns one
// result per send, ack or unused op and one resend result per expiring timer
// on a tick, the final result of an item flagged with last.
// The table lives in a one-port-read, one-port-write memory of TABLE_DEPTH
// entries; valid and timer-running flags sit in flip-flops. Every ack, tick
// and send that wants an ack walks all slots, one per cycle, through the
// memory read port before its (final) result leaves and the next item is
// taken; an item with no table work (ignored send, unused op) skips the walk
// and goes straight to its result. One item is in work at a time.
// A stalled receiver holds the output register; during a tick walk the walk
// freezes while a resend waits for room, other items wait in the final state.
// Reset (rst_n low, synchronous) empties the table, stops all timers and
// loads an attempt limit of 3 and a retry interval of 2000 ticks. No clearing
// pass. Configuration writes (cfg_we, cfg_idx, cfg_wdata) take effect at once.
// ----------------------------------------------------------------------------
module ack_retransmit_tracker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  art_pkg::art_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output art_pkg::art_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_idx,
  input  logic [15:0]       cfg_wdata
);
  import art_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_TICK   = 5'b00100,
    ST_FINISH = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  localparam logic [CNT_W-1:0] WALK_END = CNT_W'(TABLE_DEPTH);

  art_entry_t mem [TABLE_DEPTH];

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       addr_r, addr_nxt;
  logic                   chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0]       chk_idx_r, chk_idx_nxt;
  art_entry_t             rd_q_r;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [TABLE_DEPTH-1:0] run_r, run_nxt;
  logic [31:0]            key_r, key_nxt;
  logic                   is_ack_r, is_ack_nxt;
  logic                   match_v_r, match_v_nxt;
  logic [IDX_W-1:0]       match_idx_r, match_idx_nxt;
  logic [7:0]             match_att_r, match_att_nxt;
  logic                   hold_v_r, hold_v_nxt;
  logic [31:0]            hold_id_r, hold_id_nxt;
  logic [2:0]             res_kind_r, res_kind_nxt;
  logic [31:0]            res_id_r, res_id_nxt;
  logic                   out_valid_r, out_valid_nxt;
  art_out_t               out_data_r, out_data_nxt;
  logic [7:0]             max_att_r;
  logic [15:0]            retry_r;

  logic             out_ok;
  logic             expire;
  logic             pipe_stall;
  logic [IDX_W-1:0] rd_addr;
  logic             we;
  logic [IDX_W-1:0] wr_addr;
  art_entry_t       wr_data;
  logic             free_v;
  logic [IDX_W-1:0] free_idx;
  logic             walk_done;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign out_ok     = !out_valid_r || !out_stall;
  assign expire     = run_r[chk_idx_r] && (rd_q_r.countdown <= 16'd1);
  assign pipe_stall = (state_r == ST_TICK) && chk_v_r && expire && hold_v_r && !out_ok;
  assign rd_addr    = pipe_stall ? chk_idx_r : addr_r[IDX_W-1:0];
  assign walk_done  = (addr_r == WALK_END) && !chk_v_r;

  // lowest free slot
  always_comb begin
    free_v   = 1'b0;
    free_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_v   = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    chk_v_nxt     = chk_v_r;
    chk_idx_nxt   = chk_idx_r;
    valid_nxt     = valid_r;
    run_nxt       = run_r;
    key_nxt       = key_r;
    is_ack_nxt    = is_ack_r;
    match_v_nxt   = match_v_r;
    match_idx_nxt = match_idx_r;
    match_att_nxt = match_att_r;
    hold_v_nxt    = hold_v_r;
    hold_id_nxt   = hold_id_r;
    res_kind_nxt  = res_kind_r;
    res_id_nxt    = res_id_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    we            = 1'b0;
    wr_addr       = chk_idx_r;
    wr_data       = rd_q_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          key_nxt     = in_data.pkg_id;
          is_ack_nxt  = (in_data.op == OP_ACK);
          match_v_nxt = 1'b0;
          hold_v_nxt  = 1'b0;
          addr_nxt    = '0;
          chk_v_nxt   = 1'b0;
          if (in_data.op == OP_TICK) begin
            state_nxt = ST_TICK;
          end else if ((in_data.op == OP_SEND && !in_data.no_ack) ||
                       in_data.op == OP_ACK) begin
            state_nxt = ST_SCAN;
          end else begin
            res_kind_nxt = K_IGNORED;
            res_id_nxt   = in_data.pkg_id;
            state_nxt    = ST_EMIT;
          end
        end
      end

      ST_SCAN: begin
        chk_v_nxt   = (addr_r != WALK_END);
        chk_idx_nxt = addr_r[IDX_W-1:0];
        if (addr_r != WALK_END) begin
          addr_nxt = addr_r + 1'b1;
        end
        if (chk_v_r && valid_r[chk_idx_r] && rd_q_r.id == key_r) begin
          match_v_nxt   = 1'b1;
          match_idx_nxt = chk_idx_r;
          match_att_nxt = rd_q_r.attempts;
        end
        if (walk_done) begin
          res_id_nxt = key_r;
          state_nxt  = ST_EMIT;
          if (is_ack_r) begin
            if (match_v_r) begin
              valid_nxt[match_idx_r] = 1'b0;
              run_nxt[match_idx_r]   = 1'b0;
              res_kind_nxt           = K_ACKED;
            end else begin
              res_kind_nxt = K_ACK_UNKNOWN;
            end
          end else if (match_v_r) begin
            if (match_att_r < max_att_r) begin
              we                   = 1'b1;
              wr_addr              = match_idx_r;
              wr_data              = '{id: key_r, attempts: match_att_r + 8'd1,
                                       countdown: retry_r};
              run_nxt[match_idx_r] = 1'b1;
              res_kind_nxt         = K_REARM;
            end else begin
              valid_nxt[match_idx_r] = 1'b0;
              run_nxt[match_idx_r]   = 1'b0;
              res_kind_nxt           = K_GIVEUP;
            end
          end else if (free_v) begin
            we                  = 1'b1;
            wr_addr             = free_idx;
            wr_data             = '{id: key_r, attempts: 8'd1, countdown: retry_r};
            valid_nxt[free_idx] = 1'b1;
            run_nxt[free_idx]   = 1'b1;
            res_kind_nxt        = K_NEW;
          end else begin
            res_kind_nxt = K_FULL;
          end
        end
      end

      ST_TICK: begin
        if (!pipe_stall) begin
          chk_v_nxt   = (addr_r != WALK_END);
          chk_idx_nxt = addr_r[IDX_W-1:0];
          if (addr_r != WALK_END) begin
            addr_nxt = addr_r + 1'b1;
          end
          if (chk_v_r && run_r[chk_idx_r]) begin
            if (expire) begin
              // stop the timer; hold the id until we know whether it is the last
              run_nxt[chk_idx_r] = 1'b0;
              if (hold_v_r) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{kind: K_RESEND, result_id: hold_id_r, last: 1'b0};
              end
              hold_v_nxt  = 1'b1;
              hold_id_nxt = rd_q_r.id;
            end else begin
              we                = 1'b1;
              wr_data.countdown = rd_q_r.countdown - 16'd1;
            end
          end
          if (walk_done) begin
            state_nxt = ST_FINISH;
          end
        end
      end

      ST_FINISH: begin
        if (!hold_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_ok) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{kind: K_RESEND, result_id: hold_id_r, last: 1'b1};
          hold_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      ST_EMIT: begin
        if (out_ok) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{kind: res_kind_r, result_id: res_id_r, last: 1'b1};
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // slot memory: one registered read, one write per cycle
  always_ff @(posedge clk) begin
    rd_q_r <= mem[rd_addr];
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chk_v_r     <= 1'b0;
      valid_r     <= '0;
      run_r       <= '0;
      hold_v_r    <= 1'b0;
      match_v_r   <= 1'b0;
      out_valid_r <= 1'b0;
      max_att_r   <= MAX_ATTEMPTS_RST;
      retry_r     <= RETRY_TICKS_RST;
    end else begin
      state_r     <= state_nxt;
      chk_v_r     <= chk_v_nxt;
      valid_r     <= valid_nxt;
      run_r       <= run_nxt;
      hold_v_r    <= hold_v_nxt;
      match_v_r   <= match_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_idx == CFG_MAX_ATTEMPTS) begin
          max_att_r <= cfg_wdata[7:0];
        end else begin
          retry_r <= cfg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    chk_idx_r   <= chk_idx_nxt;
    key_r       <= key_nxt;
    is_ack_r    <= is_ack_nxt;
    match_idx_r <= match_idx_nxt;
    match_att_r <= match_att_nxt;
    hold_id_r   <= hold_id_nxt;
    res_kind_r  <= res_kind_nxt;
    res_id_r    <= res_id_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

// File: design/art_checker.sv
// ----------------------------------------------------------------------------
// art_checker
// Port-level checks of the ack retransmit tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "ack_retransmit_tracker_defines.svh"

module art_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input art_pkg::art_out_t out_data
);
  import art_pkg::*;

  `ART_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `ART_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "second item taken while busy")
  `ART_ASSERT(a_single_last, out_valid && out_data.kind != K_RESEND, out_data.last, "send/ack result without last")
  `ART_ASSERT(a_no_result_idle, out_valid && !in_stall && !out_data.last, 1'b0, "resend chain open while idle")

endmodule

bind ack_retransmit_tracker art_checker u_art_checker (.*);
